/* sv/pcb_pkg.sv */
// ----------------------------------------------------------------------------
// pcb_pkg
// Types, field widths and register indexes of the periodic cell binning unit.
// ----------------------------------------------------------------------------
package pcb_pkg;

    localparam int AXES         = 3;
    localparam int COMP_W       = 21;
    localparam int POS_W        = 32;
    localparam int CELL_W       = 16;
    localparam int ID_W         = 16;
    localparam int SIZE_W       = 10;
    localparam int ROW_W        = 63;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int FRAC_BITS    = 30;
    // raw floor of a Q25.30 sum (55 bits) is kept in 24 bits
    localparam int RAW_W        = 24;
    // product of one position and one component
    localparam int PROD_W       = POS_W + COMP_W;
    localparam int SUM_W        = PROD_W + 2;
    // wrap count times edge component
    localparam int SHIFT_W      = RAW_W + COMP_W + 1;
    localparam int MOVED_W      = SHIFT_W + 3;

    localparam logic [29:0] GRID_RESET = 30'h0100401;
    localparam logic [2:0]  WRAP_RESET = 3'b111;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECIP_A = 3'd0,
        REG_RECIP_B = 3'd1,
        REG_RECIP_C = 3'd2,
        REG_EDGE_A  = 3'd3,
        REG_EDGE_B  = 3'd4,
        REG_EDGE_C  = 3'd5,
        REG_GRID    = 3'd6,
        REG_WRAP    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [ID_W-1:0]         point_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]          point_id_out;
        logic signed [CELL_W-1:0] cell_a;
        logic signed [CELL_W-1:0] cell_b;
        logic signed [CELL_W-1:0] cell_c;
        logic signed [POS_W-1:0]  moved_x;
        logic signed [POS_W-1:0]  moved_y;
        logic signed [POS_W-1:0]  moved_z;
    } out_item_t;

    // pipeline handshake between stages
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

    function automatic logic signed [COMP_W-1:0] comp21(input logic [ROW_W-1:0] row,
                                                        input int k);
        comp21 = row[k*COMP_W +: COMP_W];
    endfunction

endpackage

/* sv/pcb_wrap.sv */
// ----------------------------------------------------------------------------
// pcb_wrap
// Wraps a raw cell index into [0,size) if periodic, else passes it on; its
// magnitude is reduced by restoring compare and subtract steps over three
// register stages (eight steps each); a negative index then maps into range.
// ----------------------------------------------------------------------------
module pcb_wrap (
    input  logic                              clk,
    input  logic                              adv,
    input  logic signed [pcb_pkg::RAW_W-1:0]  raw,
    input  logic [pcb_pkg::SIZE_W-1:0]        size,
    input  logic                              periodic,
    output logic signed [pcb_pkg::RAW_W-1:0]  wrapped,
    output logic signed [pcb_pkg::RAW_W-1:0]  diff
);
    import pcb_pkg::*;

    // room for the size shifted up by the top step
    localparam int DIV_W = RAW_W + SIZE_W;

    logic [SIZE_W-1:0]        sz;
    logic [RAW_W-1:0]         mag;
    logic [DIV_W-1:0]         rem1_next;
    logic [DIV_W-1:0]         rem2_next;
    logic [DIV_W-1:0]         rem3_next;
    logic [SIZE_W-1:0]        mod_val;
    logic signed [RAW_W-1:0]  raw1_reg;
    logic signed [RAW_W-1:0]  raw2_reg;
    logic [SIZE_W-1:0]        sz1_reg;
    logic [SIZE_W-1:0]        sz2_reg;
    logic                     per1_reg;
    logic                     per2_reg;
    logic [RAW_W-1:0]         rem1_reg;
    logic [RAW_W-1:0]         rem2_reg;
    logic signed [RAW_W-1:0]  wrapped_reg;
    logic signed [RAW_W-1:0]  diff_reg;

    // stage one: magnitude of the index, upper eight remainder steps
    always_comb
    begin
        sz        = (size == '0) ? SIZE_W'(1) : size;
        mag       = raw[RAW_W-1] ? RAW_W'(-raw) : RAW_W'(raw);
        rem1_next = DIV_W'(mag);
        for (int b = 23; b >= 16; b--)
        begin
            if (rem1_next >= (DIV_W'(sz) << b))
                rem1_next = rem1_next - (DIV_W'(sz) << b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            raw1_reg <= raw;
            sz1_reg  <= sz;
            per1_reg <= periodic;
            rem1_reg <= rem1_next[RAW_W-1:0];
        end
    end

    // stage two: middle eight remainder steps
    always_comb
    begin
        rem2_next = DIV_W'(rem1_reg);
        for (int b = 15; b >= 8; b--)
        begin
            if (rem2_next >= (DIV_W'(sz1_reg) << b))
                rem2_next = rem2_next - (DIV_W'(sz1_reg) << b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            raw2_reg <= raw1_reg;
            sz2_reg  <= sz1_reg;
            per2_reg <= per1_reg;
            rem2_reg <= rem2_next[RAW_W-1:0];
        end
    end

    // stage three: last eight steps, negative indices folded back into range
    always_comb
    begin
        rem3_next = DIV_W'(rem2_reg);
        for (int b = 7; b >= 0; b--)
        begin
            if (rem3_next >= (DIV_W'(sz2_reg) << b))
                rem3_next = rem3_next - (DIV_W'(sz2_reg) << b);
        end
        if (raw2_reg[RAW_W-1] && (rem3_next[SIZE_W-1:0] != '0))
            mod_val = sz2_reg - rem3_next[SIZE_W-1:0];
        else
            mod_val = rem3_next[SIZE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wrapped_reg <= per2_reg ? RAW_W'(mod_val) : raw2_reg;
            diff_reg    <= per2_reg ? raw2_reg - RAW_W'(mod_val) : '0;
        end
    end

    assign wrapped = wrapped_reg;
    assign diff    = diff_reg;

endmodule

/* sv/periodic_cell_binning_unit.sv */
// ----------------------------------------------------------------------------
// periodic_cell_binning_unit
// Cell-list binning of one particle per cycle with periodic image wrap.
// ----------------------------------------------------------------------------
// usage:
//   in (in_valid/in_ready) carries one particle position per transaction,
//   out (out_valid/out_ready) returns its cell indices and moved position.
//   cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the reciprocal
//   rows, edge vectors, grid shape and wrap mask; write only while idle.
// throughput: one transaction per cycle; six register stages each hold one
//   item (multiply, sum, three wrap stages of eight remainder steps each,
//   shift multiply), and the moved position is summed and saturated on the
//   way out of the last stage.
// stall: all stages advance together; a stalled receiver freezes the whole
//   pipeline so nothing is lost or repeated, and in_ready follows out_ready
//   whenever the final stage is full.
// reset: rst_n clears the stage valid bits and loads the registers with
//   zero rows and edges, grid 1x1x1 and all axes periodic.
// ----------------------------------------------------------------------------
module periodic_cell_binning_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  pcb_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output pcb_pkg::out_item_t                 out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pcb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pcb_pkg::*;

    localparam int STAGES = 6;

    logic [ROW_W-1:0]   recip_reg [AXES];
    logic [ROW_W-1:0]   edge_reg  [AXES];
    logic [29:0]        grid_reg;
    logic [2:0]         wrap_reg;
    logic [STAGES-1:0]  vld_reg;
    stage_ctl_t         ctl;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                recip_reg[a] <= '0;
                edge_reg[a]  <= '0;
            end
            grid_reg <= GRID_RESET;
            wrap_reg <= WRAP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RECIP_A: recip_reg[0] <= cfg_data[ROW_W-1:0];
                REG_RECIP_B: recip_reg[1] <= cfg_data[ROW_W-1:0];
                REG_RECIP_C: recip_reg[2] <= cfg_data[ROW_W-1:0];
                REG_EDGE_A:  edge_reg[0]  <= cfg_data[ROW_W-1:0];
                REG_EDGE_B:  edge_reg[1]  <= cfg_data[ROW_W-1:0];
                REG_EDGE_C:  edge_reg[2]  <= cfg_data[ROW_W-1:0];
                REG_GRID:    grid_reg     <= cfg_data[29:0];
                REG_WRAP:    wrap_reg     <= cfg_data[2:0];
                default:     ;
            endcase
        end
    end

    // global stall: advance unless the output is full and not taken
    assign ctl.advance = !vld_reg[STAGES-1] || out_ready;
    assign ctl.valid   = in_valid;
    assign in_ready    = ctl.advance;
    assign out_valid   = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ctl.advance)
            vld_reg <= {vld_reg[STAGES-2:0], ctl.valid};
    end

    // payload pipeline
    logic [ID_W-1:0]         id_reg  [STAGES];
    logic signed [POS_W-1:0] pos_reg [STAGES][AXES];
    logic signed [PROD_W-1:0] prod_reg [AXES][AXES];
    logic signed [SUM_W-1:0]  frac_reg [AXES];
    logic signed [RAW_W-1:0]  raw_floor [AXES];
    logic signed [RAW_W-1:0]  wrp      [AXES];
    logic signed [RAW_W-1:0]  dif      [AXES];
    logic signed [SHIFT_W-1:0] sh_reg  [AXES][AXES];
    logic signed [CELL_W-1:0] cell_reg [AXES];
    logic signed [CELL_W-1:0] cell_sat [AXES];
    logic signed [POS_W-1:0]  in_pos   [AXES];

    assign in_pos[0] = in_data.pos_x;
    assign in_pos[1] = in_data.pos_y;
    assign in_pos[2] = in_data.pos_z;

    // stage 1: products, stage 2: sums
    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            id_reg[0] <= in_data.point_id;
            for (int s = 1; s < STAGES; s++)
                id_reg[s] <= id_reg[s-1];
            for (int k = 0; k < AXES; k++)
            begin
                pos_reg[0][k] <= in_pos[k];
                for (int s = 1; s < STAGES; s++)
                    pos_reg[s][k] <= pos_reg[s-1][k];
            end
            for (int a = 0; a < AXES; a++)
            begin
                for (int k = 0; k < AXES; k++)
                    prod_reg[a][k] <= PROD_W'(in_pos[k]) * PROD_W'(comp21(recip_reg[a], k));
                frac_reg[a] <= SUM_W'(prod_reg[a][0]) + SUM_W'(prod_reg[a][1])
                             + SUM_W'(prod_reg[a][2]);
            end
        end
    end

    // stages 3-5: floor and wrap into the grid
    for (genvar a = 0; a < AXES; a++)
    begin : g_wrap
        // arithmetic shift is a floor
        assign raw_floor[a] = RAW_W'(frac_reg[a] >>> FRAC_BITS);

        pcb_wrap u_wrap (
            .clk      (clk),
            .adv      (ctl.advance),
            .raw      (raw_floor[a]),
            .size     (grid_reg[a*SIZE_W +: SIZE_W]),
            .periodic (wrap_reg[a]),
            .wrapped  (wrp[a]),
            .diff     (dif[a])
        );
        always_comb
        begin
            if (wrp[a] > RAW_W'(32767))
                cell_sat[a] = 16'sh7fff;
            else if (wrp[a] < -RAW_W'(32768))
                cell_sat[a] = -16'sh8000;
            else
                cell_sat[a] = CELL_W'(wrp[a]);
        end
    end

    // stage 6: shift products and saturated cells
    logic signed [MOVED_W-1:0] mv [AXES];
    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                cell_reg[a] <= cell_sat[a];
                for (int k = 0; k < AXES; k++)
                    sh_reg[a][k] <= SHIFT_W'(dif[a]) * SHIFT_W'(comp21(edge_reg[a], k));
            end
        end
    end

    // sum of shifts and saturation
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
            mv[k] = MOVED_W'(pos_reg[STAGES-1][k]) - MOVED_W'(sh_reg[0][k])
                  - MOVED_W'(sh_reg[1][k]) - MOVED_W'(sh_reg[2][k]);
    end

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [MOVED_W-1:0] v);
        if (v > MOVED_W'(32'sh7fffffff))
            sat32 = 32'sh7fffffff;
        else if (v < -MOVED_W'(33'sh080000000))
            sat32 = 32'sh80000000;
        else
            sat32 = POS_W'(v);
    endfunction

    assign out_data = '{point_id_out: id_reg[STAGES-1],
                        cell_a: cell_reg[0], cell_b: cell_reg[1],
                        cell_c: cell_reg[2],
                        moved_x: sat32(mv[0]), moved_y: sat32(mv[1]),
                        moved_z: sat32(mv[2])};

    // stalled output holds its contents
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed under stall");

    // advance bookkeeping: accepted input appears as stage one valid
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted item lost");

    // a periodic cell on the first axis is never negative
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wrap_reg[0] |-> cell_reg[0] >= 0)
        else $error("wrapped cell negative");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for periodic_cell_binning_unit
// Drives particle positions through the binning pipeline under several
// register settings and idle patterns, predicts each result with an
// independent fixed-point model and checks every output field in order.
// ----------------------------------------------------------------------------

// expected-result store with its own copy of the register state
class binning_scoreboard;
    logic [62:0] recip[3];
    logic [62:0] edges[3];
    logic [29:0] shape;
    logic [2:0]  periodic;
    pcb_pkg::out_item_t pending[$];
    int mismatches;
    int checked;

    function new();
        reset_regs();
        mismatches = 0;
        checked = 0;
    endfunction

    function void reset_regs();
        for (int a = 0; a < 3; a++)
        begin
            recip[a] = '0;
            edges[a] = '0;
        end
        shape = pcb_pkg::GRID_RESET;
        periodic = pcb_pkg::WRAP_RESET;
    endfunction

    function void write_reg(pcb_pkg::cfg_reg_t idx, logic [63:0] value);
        case (idx)
            pcb_pkg::REG_RECIP_A: recip[0] = value[62:0];
            pcb_pkg::REG_RECIP_B: recip[1] = value[62:0];
            pcb_pkg::REG_RECIP_C: recip[2] = value[62:0];
            pcb_pkg::REG_EDGE_A:  edges[0] = value[62:0];
            pcb_pkg::REG_EDGE_B:  edges[1] = value[62:0];
            pcb_pkg::REG_EDGE_C:  edges[2] = value[62:0];
            pcb_pkg::REG_GRID:    shape = value[29:0];
            default:              periodic = value[2:0];
        endcase
    endfunction

    function longint part(logic [62:0] row, int k);
        logic signed [20:0] c;
        c = row[k*21 +: 21];
        return longint'(c);
    endfunction

    // floor of a Q.30 value toward minus infinity
    function longint floor30(longint v);
        return v >>> 30;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // note an accepted input and queue its expected result
    function void note_input(pcb_pkg::in_item_t item);
        pcb_pkg::out_item_t res;
        longint pos[3];
        longint moved[3];
        longint cellv[3];
        longint frac;
        longint raw;
        longint wrapped;
        longint size;
        pos[0] = longint'(item.pos_x);
        pos[1] = longint'(item.pos_y);
        pos[2] = longint'(item.pos_z);
        for (int k = 0; k < 3; k++)
            moved[k] = pos[k];
        for (int a = 0; a < 3; a++)
        begin
            frac = 0;
            for (int k = 0; k < 3; k++)
                frac += pos[k] * part(recip[a], k);
            raw = floor30(frac);
            wrapped = raw;
            if (periodic[a])
            begin
                size = longint'(shape[a*10 +: 10]);
                if (size == 0)
                    size = 1;
                wrapped = raw % size;
                if (wrapped < 0)
                    wrapped += size;
            end
            for (int k = 0; k < 3; k++)
                moved[k] -= (raw - wrapped) * part(edges[a], k);
            cellv[a] = clamp(wrapped, -32768, 32767);
        end
        res.point_id_out = item.point_id;
        res.cell_a = cellv[0][15:0];
        res.cell_b = cellv[1][15:0];
        res.cell_c = cellv[2][15:0];
        res.moved_x = 32'(clamp(moved[0], -64'sd2147483648, 64'sd2147483647));
        res.moved_y = 32'(clamp(moved[1], -64'sd2147483648, 64'sd2147483647));
        res.moved_z = 32'(clamp(moved[2], -64'sd2147483648, 64'sd2147483647));
        pending.push_back(res);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h actual %h", what, want, got);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(pcb_pkg::out_item_t got);
        pcb_pkg::out_item_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transaction: %h", got);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got.point_id_out !== want.point_id_out)
            report("point_id_out", want.point_id_out, got.point_id_out);
        if (got.cell_a !== want.cell_a)
            report("cell_a", want.cell_a, got.cell_a);
        if (got.cell_b !== want.cell_b)
            report("cell_b", want.cell_b, got.cell_b);
        if (got.cell_c !== want.cell_c)
            report("cell_c", want.cell_c, got.cell_c);
        if (got.moved_x !== want.moved_x)
            report("moved_x", want.moved_x, got.moved_x);
        if (got.moved_y !== want.moved_y)
            report("moved_y", want.moved_y, got.moved_y);
        if (got.moved_z !== want.moved_z)
            report("moved_z", want.moved_z, got.moved_z);
    endfunction
endclass

module testbench;
    import pcb_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    binning_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    int sent;
    int configs_done;

    periodic_cell_binning_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver side: random stalls and result checking
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                board.check_result(out_data);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one register write transaction, after which cfg_valid is dropped again
    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one input transaction, with optional idle cycles ahead of it
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        in_item_t item;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        item.point_id = sent[15:0] ^ 16'($urandom_range(65535));
        item.pos_x = x;
        item.pos_y = y;
        item.pos_z = z;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_input(item);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [62:0] pack3(logic [20:0] x, logic [20:0] y, logic [20:0] z);
        return {z, y, x};
    endfunction

    // random reciprocal component: full 21-bit range, within +-2000, or 0 to 2^17
    function automatic logic [20:0] rand_comp();
        case ($urandom_range(3))
            0: return 21'($urandom_range(2097151));
            1: return 21'(int'($urandom_range(4000)) - 2000);
            default: return 21'($urandom_range(1 << 17));
        endcase
    endfunction

    task automatic random_setting();
        write_reg(REG_RECIP_A, {1'b1, pack3(rand_comp(), rand_comp(), rand_comp())});
        write_reg(REG_RECIP_B, {1'b0, pack3(rand_comp(), rand_comp(), rand_comp())});
        write_reg(REG_RECIP_C, {1'b1, pack3(rand_comp(), rand_comp(), rand_comp())});
        write_reg(REG_EDGE_A, {$urandom, $urandom});
        write_reg(REG_EDGE_B, {32'd0, 11'd0, 21'($urandom_range(8191))});
        write_reg(REG_EDGE_C, {$urandom, $urandom});
        write_reg(REG_GRID, 64'({$urandom_range(1023) > 100 ? 10'($urandom_range(15)) : 10'd0,
                                 10'($urandom_range(1023)), 10'($urandom_range(7))}));
        write_reg(REG_WRAP, 64'($urandom_range(7)));
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'(int'($urandom_range(20000)) - 10000);
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'(int'($urandom_range(1 << 22)) - (1 << 21));
        endcase
    endfunction

    task automatic random_phase(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count)
            send_point(rand_pos(), rand_pos(), rand_pos());
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sent = 0;
        configs_done = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: everything lands in cell zero, no move
        send_point(32'h7fffffff, 32'h80000000, 32'h0);
        drain();

        // unit reciprocal rows, 1.0 edges, 4x3x2 grid, all periodic
        write_reg(REG_RECIP_A, 64'(pack3(21'h0fffff, 21'd0, 21'd0)));
        write_reg(REG_RECIP_B, 64'(pack3(21'd0, 21'h0fffff, 21'd0)));
        write_reg(REG_RECIP_C, 64'(pack3(21'd0, 21'd0, 21'h0fffff)));
        write_reg(REG_EDGE_A, 64'(pack3(21'd1024, 21'd0, 21'd0)));
        write_reg(REG_EDGE_B, 64'(pack3(21'd0, 21'd1024, 21'd0)));
        write_reg(REG_EDGE_C, 64'(pack3(21'd0, 21'd0, 21'd1024)));
        write_reg(REG_GRID, 64'({10'd2, 10'd3, 10'd4}));
        write_reg(REG_WRAP, 64'd7);
        send_point(32'd0, 32'd0, 32'd0);
        send_point(32'd5 << 10, -32'sd1, 32'd3 << 10);
        send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_point(32'h80000000, 32'h7fffffff, -32'sd1024);
        drain();

        // extreme rows, saturation of cells and moves, zero grid size, mixed wrap
        write_reg(REG_RECIP_A, {1'b0, pack3(21'h100000, 21'h100000, 21'h100000)});
        write_reg(REG_RECIP_B, 64'(pack3(21'h0fffff, 21'h0fffff, 21'h0fffff)));
        write_reg(REG_RECIP_C, 64'hffffffffffffffff);
        write_reg(REG_EDGE_A, 64'(pack3(21'h0fffff, 21'h100000, 21'h0fffff)));
        write_reg(REG_EDGE_B, 64'(pack3(21'h100000, 21'h0fffff, 21'h100000)));
        write_reg(REG_EDGE_C, 64'h7fffffffffffffff);
        write_reg(REG_GRID, 64'({10'd1023, 10'd0, 10'd0}));
        write_reg(REG_WRAP, 64'd1);
        send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'h12345678, 32'hedcba987, 32'h0);
        drain();
        write_reg(REG_WRAP, 64'd6);
        send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_point(32'h80000000, 32'h7fffffff, 32'h00000400);
        drain();
        write_reg(REG_WRAP, 64'd0);
        send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        drain();

        // random settings, each under one idle pattern
        for (int p = 0; p < 16; p++)
        begin
            random_setting();
            configs_done++;
            case (p % 4)
                0: random_phase(40, 0, 0);
                1: random_phase(40, 54, 0);
                2: random_phase(40, 0, 54);
                default: random_phase(40, 8, 8);
            endcase
            drain();
        end

        $display("covered %0d positions over %0d random register settings, %0d checked",
                 sent, configs_done, board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("[periodic_cell_binning_unit] OK");
        else
            $display("[periodic_cell_binning_unit] ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("timeout with %0d results outstanding", board.pending.size());
        $display("[periodic_cell_binning_unit] ERROR");
        $finish;
    end
endmodule

/* files.f */
sv/pcb_pkg.sv
sv/pcb_wrap.sv
sv/periodic_cell_binning_unit.sv
tb/sv/testbench.sv
